FILE: hdl/pcrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrr_pkg
// Shared types, constants and the rounding shift of the pointwise
// convolution block with residual requantisation.
// ----------------------------------------------------------------------------
package pcrr_pkg;

  localparam int MAX_WIDTH_DEF       = 32;
  localparam int MAX_IN_CHANNELS_DEF = 64;
  localparam int MAX_OUT_CHANNELS_DEF = 64;

  localparam int POS_W      = 12;
  localparam int BYTE_W     = 8;
  localparam int OUT_POS_W  = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int PROD_W     = 17;
  localparam int RND_W      = 33;

  localparam logic [4:0] CONV_SHIFT_RST     = 5'd10;
  localparam logic [4:0] RES_SHIFT_RST      = 5'd0;
  localparam logic [5:0] ROW_WIDTH_RST      = 6'd32;
  localparam logic [6:0] IN_CH_RST          = 7'd64;
  localparam logic [6:0] OUT_CH_RST         = 7'd64;
  localparam logic       RES_SIGNED_RST     = 1'b1;

  typedef enum logic [1:0] {
    MODE_WEIGHT     = 2'd0,
    MODE_ACT_FIRST  = 2'd1,
    MODE_ACT_SECOND = 2'd2,
    MODE_COMPUTE    = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONV_SHIFT = 3'd0,
    CFG_RES_SHIFT  = 3'd1,
    CFG_ROW_WIDTH  = 3'd2,
    CFG_IN_CH      = 3'd3,
    CFG_OUT_CH     = 3'd4,
    CFG_RES_SIGNED = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

  // round half up, then arithmetic shift right
  function automatic logic signed [RND_W-1:0] round_shift(
    input logic signed [RND_W-1:0] v,
    input logic [4:0]              s
  );
    logic signed [RND_W-1:0] bias;
    bias = '0;
    if (s != 5'd0) begin
      bias[s - 5'd1] = 1'b1;
    end
    return (v + bias) >>> s;
  endfunction

endpackage

FILE: hdl/pcrr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrr_in_if / pcrr_out_if
// Valid/ready channels carrying input and result transactions.
// ----------------------------------------------------------------------------
interface pcrr_in_if;
  import pcrr_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [POS_W-1:0]    position;
  logic [BYTE_W-1:0]   data_byte;

  modport source (output valid, output mode, output position, output data_byte, input ready);
  modport sink   (input valid, input mode, input position, input data_byte, output ready);
endinterface

interface pcrr_out_if;
  import pcrr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUT_POS_W-1:0] out_position;
  logic [BYTE_W-1:0]    out_value;

  modport source (output valid, output out_position, output out_value, input ready);
  modport sink   (input valid, input out_position, input out_value, output ready);
endinterface

FILE: hdl/pcrr_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcrr_mac
// Shared multiply-accumulate unit: uint8 x int8 product register followed
// by the accumulator.
// ----------------------------------------------------------------------------
module pcrr_mac #(
  parameter int SUM_W = 23
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcrr_pkg::mac_ctrl_t         ctrl_i,
  input  logic [pcrr_pkg::BYTE_W-1:0] act_i,
  input  logic [pcrr_pkg::BYTE_W-1:0] wgt_i,
  output logic signed [SUM_W-1:0]     acc_o,
  output logic                        busy_o
);
  import pcrr_pkg::*;

  logic signed [PROD_W-1:0] act_ext;
  logic signed [PROD_W-1:0] wgt_ext;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  logic                     pv_q;
  logic signed [SUM_W-1:0]  acc_q;

  assign act_ext = PROD_W'({1'b0, act_i});
  assign wgt_ext = PROD_W'($signed(wgt_i));
  assign prod_d  = act_ext * wgt_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      pv_q   <= ctrl_i.vld;
      prod_q <= prod_d;
      if (ctrl_i.clr) begin
        acc_q <= '0;
      end else if (pv_q) begin
        acc_q <= acc_q + SUM_W'(prod_q);
      end
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = pv_q;

endmodule

FILE: hdl/pointwise_conv_residual_requant.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointwise_conv_residual_requant
// 1x1 convolution of one pixel row with residual add and requantisation.
// ----------------------------------------------------------------------------
// in_i carries transactions: modes 0..2 write a weight or an activation byte
// at the given store index and give no result; mode 3 names an output
// position and brings its residual byte, and gives one result on out_o
// unless the position lies beyond the row.
// A compute transaction first divides position / 8 by the row width in a
// subtract loop to find the output channel block, then runs the shared
// multiplier at one product per cycle over the in channels (64 products at
// full channel count), drains the product pipeline and rounds the conv sum
// and then the residual sum. With fewer than 16 in channels the products and
// the drain drop out, and a position beyond the row ends after the division.
// in_i.ready is high only while the block is idle.
// A finished result waits in the output register; the next transaction is
// accepted meanwhile, and a later compute holds its result until out_o frees.
// cfg_* writes a register at an edge with cfg_we_i; the user must do so only
// while idle, as the block does not enforce it. Reset clears control and
// restores register defaults; stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module pointwise_conv_residual_requant #(
  parameter int MAX_WIDTH        = pcrr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_IN_CHANNELS  = pcrr_pkg::MAX_IN_CHANNELS_DEF,
  parameter int MAX_OUT_CHANNELS = pcrr_pkg::MAX_OUT_CHANNELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pcrr_in_if.sink                         in_i,
  pcrr_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [pcrr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcrr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pcrr_pkg::*;

  localparam int W_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS;
  localparam int A_DEPTH = (MAX_IN_CHANNELS / 2) * MAX_WIDTH;
  localparam int WAW     = $clog2(W_DEPTH);
  localparam int AAW     = $clog2(A_DEPTH);
  localparam int W_W     = $clog2(MAX_WIDTH + 1);
  localparam int ICB_MAX = MAX_IN_CHANNELS / 16;
  localparam int ICB_W   = $clog2(ICB_MAX + 1);
  localparam int OCB_MAX = MAX_OUT_CHANNELS / 8;
  localparam int OCB_W   = $clog2(OCB_MAX + 1);
  localparam int SUM_W   = PROD_W + $clog2(MAX_IN_CHANNELS);
  localparam int REM_W   = POS_W - 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MAC,
    S_DRAIN,
    S_RCONV,
    S_RRES
  } state_e;

  // configuration
  logic [4:0] conv_shift_q;
  logic [4:0] res_shift_q;
  logic [5:0] row_width_q;
  logic [6:0] in_ch_q;
  logic [6:0] out_ch_q;
  logic       res_signed_q;

  logic [W_W-1:0]   w_eff;
  logic [ICB_W-1:0] icb;
  logic [OCB_W-1:0] ocb;

  // sequencer
  state_e               state_q;
  logic [REM_W-1:0]     rem_q;
  logic [OCB_W-1:0]     oc_q;
  logic [WAW-1:0]       wbase_q;
  logic [WAW-1:0]       wptr_q;
  logic [AAW-1:0]       abase_q;
  logic [AAW-1:0]       xoff_q;
  logic [2:0]           i_q;
  logic [ICB_W-1:0]     c_q;
  logic                 half_q;
  logic [2:0]           oc8_q;
  logic [OUT_POS_W-1:0] pos_q;
  logic [BYTE_W-1:0]    res_q;
  logic                 rv_q;
  logic                 rh_q;
  logic signed [8:0]    conv_q;
  logic                 out_valid_q;
  logic [OUT_POS_W-1:0] out_pos_q;
  logic [BYTE_W-1:0]    out_value_q;

  // stores
  logic [BYTE_W-1:0] wmem   [W_DEPTH];
  logic [BYTE_W-1:0] amem1  [A_DEPTH];
  logic [BYTE_W-1:0] amem2  [A_DEPTH];
  logic [BYTE_W-1:0] wrd_q;
  logic [BYTE_W-1:0] a1rd_q;
  logic [BYTE_W-1:0] a2rd_q;

  logic             in_acc;
  logic             ld_w;
  logic             ld_a1;
  logic             ld_a2;
  logic             start;
  logic [AAW-1:0]   aaddr;
  logic [WAW-1:0]   ld_waddr;
  logic [AAW-1:0]   ld_aaddr;

  mac_ctrl_t               mac_ctrl;
  logic signed [SUM_W-1:0] acc;
  logic                    mac_busy;

  logic signed [8:0]       res_ext;
  logic signed [RND_W-1:0] rnd_in;
  logic [4:0]              rnd_s;
  logic signed [RND_W-1:0] rnd_out;
  logic signed [8:0]       conv_clip;
  logic [BYTE_W-1:0]       res_clip;

  // effective geometry
  always_comb begin
    if (row_width_q == '0) begin
      w_eff = W_W'(1);
    end else if (32'(row_width_q) > MAX_WIDTH) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = W_W'(row_width_q);
    end
    if (32'(in_ch_q[6:4]) > ICB_MAX) begin
      icb = ICB_W'(ICB_MAX);
    end else begin
      icb = ICB_W'(in_ch_q[6:4]);
    end
    if (32'(out_ch_q[6:3]) > OCB_MAX) begin
      ocb = OCB_W'(OCB_MAX);
    end else begin
      ocb = OCB_W'(out_ch_q[6:3]);
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign ld_w       = in_acc && (in_i.mode == MODE_WEIGHT) && (32'(in_i.position) < W_DEPTH);
  assign ld_a1      = in_acc && (in_i.mode == MODE_ACT_FIRST) && (32'(in_i.position) < A_DEPTH);
  assign ld_a2      = in_acc && (in_i.mode == MODE_ACT_SECOND) && (32'(in_i.position) < A_DEPTH);
  assign start      = in_acc && (in_i.mode == MODE_COMPUTE);
  assign ld_waddr   = WAW'(in_i.position);
  assign ld_aaddr   = AAW'(in_i.position);
  assign aaddr      = abase_q + AAW'(i_q);

  always_ff @(posedge clk_i) begin
    if (ld_w) begin
      wmem[ld_waddr] <= in_i.data_byte;
    end
    if (ld_a1) begin
      amem1[ld_aaddr] <= in_i.data_byte;
    end
    if (ld_a2) begin
      amem2[ld_aaddr] <= in_i.data_byte;
    end
    wrd_q  <= wmem[wptr_q];
    a1rd_q <= amem1[aaddr];
    a2rd_q <= amem2[aaddr];
  end

  assign mac_ctrl = '{clr: start, vld: rv_q};

  pcrr_mac #(
    .SUM_W (SUM_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .act_i  (rh_q ? a2rd_q : a1rd_q),
    .wgt_i  (wrd_q),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  // shared rounding shifter: conv sum first, then residual sum
  assign res_ext = res_signed_q ? $signed({res_q[7], res_q}) : $signed({1'b0, res_q});

  always_comb begin
    if (state_q == S_RCONV) begin
      rnd_in = RND_W'(acc);
      rnd_s  = conv_shift_q;
    end else begin
      rnd_in = RND_W'(conv_q) + RND_W'(res_ext);
      rnd_s  = res_shift_q;
    end
    rnd_out = round_shift(rnd_in, rnd_s);
    if (rnd_out < -33'sd128) begin
      conv_clip = -9'sd128;
    end else if (rnd_out > 33'sd127) begin
      conv_clip = 9'sd127;
    end else begin
      conv_clip = rnd_out[8:0];
    end
    if (rnd_out < 33'sd0) begin
      res_clip = 8'd0;
    end else if (rnd_out > 33'sd255) begin
      res_clip = 8'd255;
    end else begin
      res_clip = rnd_out[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_shift_q <= CONV_SHIFT_RST;
      res_shift_q  <= RES_SHIFT_RST;
      row_width_q  <= ROW_WIDTH_RST;
      in_ch_q      <= IN_CH_RST;
      out_ch_q     <= OUT_CH_RST;
      res_signed_q <= RES_SIGNED_RST;
      state_q      <= S_IDLE;
      rv_q         <= 1'b0;
      rh_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      rem_q        <= '0;
      oc_q         <= '0;
      wbase_q      <= '0;
      wptr_q       <= '0;
      abase_q      <= '0;
      xoff_q       <= '0;
      i_q          <= '0;
      c_q          <= '0;
      half_q       <= 1'b0;
      oc8_q        <= '0;
      pos_q        <= '0;
      res_q        <= '0;
      conv_q       <= '0;
      out_pos_q    <= '0;
      out_value_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CONV_SHIFT: conv_shift_q <= cfg_data_i[4:0];
          CFG_RES_SHIFT:  res_shift_q  <= cfg_data_i[4:0];
          CFG_ROW_WIDTH:  row_width_q  <= cfg_data_i[5:0];
          CFG_IN_CH:      in_ch_q      <= cfg_data_i;
          CFG_OUT_CH:     out_ch_q     <= cfg_data_i;
          CFG_RES_SIGNED: res_signed_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      if ((state_q == S_RRES) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      rv_q <= (state_q == S_MAC);

      case (state_q)
        S_IDLE: begin
          if (start) begin
            rem_q   <= in_i.position[POS_W-1:3];
            oc8_q   <= in_i.position[2:0];
            pos_q   <= in_i.position[OUT_POS_W-1:0];
            res_q   <= in_i.data_byte;
            oc_q    <= '0;
            wbase_q <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (32'(rem_q) < 32'(w_eff)) begin
            if (oc_q < ocb) begin
              wptr_q  <= wbase_q + WAW'(oc8_q);
              abase_q <= AAW'({rem_q, 3'b000});
              xoff_q  <= AAW'({rem_q, 3'b000});
              i_q     <= '0;
              c_q     <= '0;
              half_q  <= 1'b0;
              state_q <= (icb == '0) ? S_RCONV : S_MAC;
            end else begin
              state_q <= S_IDLE;
            end
          end else if (oc_q == ocb) begin
            state_q <= S_IDLE;
          end else begin
            rem_q   <= REM_W'(32'(rem_q) - 32'(w_eff));
            oc_q    <= oc_q + OCB_W'(1);
            wbase_q <= wbase_q + WAW'(32'(icb) << 7);
          end
        end
        S_MAC: begin
          rh_q   <= half_q;
          wptr_q <= wptr_q + WAW'(8);
          if (i_q == 3'd7) begin
            i_q <= '0;
            if (32'(c_q) + 1 == 32'(icb)) begin
              c_q <= '0;
              if (half_q) begin
                state_q <= S_DRAIN;
              end else begin
                half_q  <= 1'b1;
                abase_q <= xoff_q;
              end
            end else begin
              c_q     <= c_q + ICB_W'(1);
              abase_q <= abase_q + AAW'(32'(w_eff) << 3);
            end
          end else begin
            i_q <= i_q + 3'd1;
          end
        end
        S_DRAIN: begin
          if (!rv_q && !mac_busy) begin
            state_q <= S_RCONV;
          end
        end
        S_RCONV: begin
          conv_q  <= conv_clip;
          state_q <= S_RRES;
        end
        S_RRES: begin
          if (!out_valid_q || out_o.ready) begin
            out_pos_q   <= pos_q;
            out_value_q <= res_clip;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_position = out_pos_q;
  assign out_o.out_value    = out_value_q;

`ifndef NO_ASSERTIONS
  a_round_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RCONV |-> !mac_busy && !rv_q)
    else $error("rounding started with products still in flight");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> oc_q <= ocb)
    else $error("channel block count overran");

  a_issue_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> $past(state_q == S_MAC))
    else $error("store read issued outside accumulation");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RRES))
    else $error("result raised outside final stage");

  a_compute_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> state_q == S_DIV)
    else $error("compute transaction did not start");
`endif

endmodule

FILE: bench/pointwise_conv_residual_requant_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointwise_conv_residual_requant_tb
// Self-checking bench for the 1x1 convolution with residual requantisation.
// Fills every store, runs directed transactions on the register corners, then
// random phases of loads and computes under random register settings. A
// scoreboard keeps its own copy of the stores and registers, predicts each
// requantised pixel and checks results in order. Both channels stall at random.
// ----------------------------------------------------------------------------
module pointwise_conv_residual_requant_tb;
  import pcrr_pkg::*;

  localparam int WGT_DEPTH     = MAX_OUT_CHANNELS_DEF * MAX_IN_CHANNELS_DEF;
  localparam int ACT_DEPTH     = MAX_IN_CHANNELS_DEF / 2 * MAX_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 640;
  localparam int STALL_LIMIT   = 20000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 170;
  localparam int PRINT_CAP     = 50;

  class pixel_scoreboard;
    typedef struct packed {
      logic [OUT_POS_W-1:0] position;
      logic [BYTE_W-1:0]    value;
    } pixel_t;

    logic [7:0] weights     [WGT_DEPTH];
    logic [7:0] acts_first  [ACT_DEPTH];
    logic [7:0] acts_second [ACT_DEPTH];
    logic [4:0] conv_shift;
    logic [4:0] res_shift;
    logic [5:0] row_width;
    logic [6:0] in_ch;
    logic [6:0] out_ch;
    logic       res_signed;
    pixel_t     expected_pixels [$];
    int         mismatches;

    function new();
      foreach (weights[k]) weights[k] = '0;
      foreach (acts_first[k]) acts_first[k] = '0;
      foreach (acts_second[k]) acts_second[k] = '0;
      conv_shift = CONV_SHIFT_RST;
      res_shift  = RES_SHIFT_RST;
      row_width  = ROW_WIDTH_RST;
      in_ch      = IN_CH_RST;
      out_ch     = OUT_CH_RST;
      res_signed = RES_SIGNED_RST;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_CONV_SHIFT: conv_shift = v[4:0];
        CFG_RES_SHIFT:  res_shift  = v[4:0];
        CFG_ROW_WIDTH:  row_width  = v[5:0];
        CFG_IN_CH:      in_ch      = v[6:0];
        CFG_OUT_CH:     out_ch     = v[6:0];
        CFG_RES_SIGNED: res_signed = v[0];
        default: ;
      endcase
    endfunction

    // half-up rounding, floor shift
    function longint shift_round(longint v, int unsigned s);
      if (s == 0) return v;
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function void accept_item(mode_e m, logic [POS_W-1:0] p, logic [BYTE_W-1:0] b);
      int unsigned w, icb, ocb, col, blk, lane, ai, wa, wb;
      longint      sum, conv, acc;
      pixel_t      px;
      case (m)
        MODE_WEIGHT: begin
          if (p < WGT_DEPTH) weights[p] = b;
        end
        MODE_ACT_FIRST: begin
          if (p < ACT_DEPTH) acts_first[p] = b;
        end
        MODE_ACT_SECOND: begin
          if (p < ACT_DEPTH) acts_second[p] = b;
        end
        default: begin
          w = (row_width == 0) ? 1 : row_width;
          if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
          icb = in_ch / 16;
          if (icb > MAX_IN_CHANNELS_DEF / 16) icb = MAX_IN_CHANNELS_DEF / 16;
          ocb = out_ch / 8;
          if (ocb > MAX_OUT_CHANNELS_DEF / 8) ocb = MAX_OUT_CHANNELS_DEF / 8;
          if ((p >> 3) >= ocb * w) return;
          lane = p & 7;
          col  = (p >> 3) % w;
          blk  = (p >> 3) / w;
          sum  = 0;
          for (int c = 0; c < icb; c++) begin
            for (int i = 0; i < 8; i++) begin
              ai = c * w * 8 + col * 8 + i;
              wa = blk * icb * 128 + c * 64 + i * 8 + lane;
              wb = wa + icb * 64;
              if (ai < ACT_DEPTH && wb < WGT_DEPTH) begin
                sum += longint'(acts_first[ai]) * longint'($signed(weights[wa]));
                sum += longint'(acts_second[ai]) * longint'($signed(weights[wb]));
              end
            end
          end
          conv = shift_round(sum, conv_shift);
          if (conv < -128) conv = -128;
          else if (conv > 127) conv = 127;
          acc = conv + (res_signed ? longint'($signed(b)) : longint'(b));
          acc = shift_round(acc, res_shift);
          if (acc < 0) acc = 0;
          else if (acc > 255) acc = 255;
          px.position = p[OUT_POS_W-1:0];
          px.value    = acc[7:0];
          expected_pixels.push_back(px);
        end
      endcase
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t: mismatch: %s", $time, what);
    endtask

    task check_pixel(logic [OUT_POS_W-1:0] p, logic [BYTE_W-1:0] v);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected result, position %0d value %0d", p, v));
        return;
      end
      want = expected_pixels.pop_front();
      if (p !== want.position)
        report($sformatf("position %0d, expected %0d", p, want.position));
      if (v !== want.value)
        report($sformatf("value %0d at position %0d, expected %0d", v, want.position,
                         want.value));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    idle_pct = 38;
  int                    stall_cycles = 0;
  pixel_scoreboard       sb;

  pcrr_in_if  in_bus ();
  pcrr_out_if out_bus ();

  pointwise_conv_residual_requant dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      sb.check_pixel(out_bus.out_position, out_bus.out_value);
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  // entered and left at a falling edge
  task automatic push_item(mode_e m, logic [POS_W-1:0] p, logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.mode      <= m;
    in_bus.position  <= p;
    in_bus.data_byte <= b;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.accept_item(m, p, b);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.write_reg(idx, v);
    @(negedge clk_i);
  endtask

  // block idle: every result in, then room for a compute that gives none
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic configure(logic [4:0] cs, logic [4:0] rs, logic [5:0] rw,
                           logic [6:0] ic, logic [6:0] oc, logic sg);
    settle();
    write_reg(CFG_CONV_SHIFT, CFG_DATA_W'(cs));
    write_reg(CFG_RES_SHIFT, CFG_DATA_W'(rs));
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(rw));
    write_reg(CFG_IN_CH, ic);
    write_reg(CFG_OUT_CH, oc);
    write_reg(CFG_RES_SIGNED, CFG_DATA_W'(sg));
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_item();
    int unsigned   roll, w, ocb, span;
    mode_e         m;
    logic [POS_W-1:0] p;
    roll = $urandom_range(99);
    if (roll < 55) begin
      m = MODE_COMPUTE;
      w = (sb.row_width == 0) ? 1 : ((sb.row_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF
                                                                    : sb.row_width);
      ocb = sb.out_ch / 8;
      if (ocb > MAX_OUT_CHANNELS_DEF / 8) ocb = MAX_OUT_CHANNELS_DEF / 8;
      span = ocb * w * 8;
      if (span > 0 && $urandom_range(99) < 85) p = POS_W'($urandom_range(span - 1, 0));
      else p = POS_W'($urandom_range(4095, 0));
    end else begin
      m = (roll < 80) ? MODE_WEIGHT : ((roll < 90) ? MODE_ACT_FIRST : MODE_ACT_SECOND);
      if (m == MODE_WEIGHT || $urandom_range(99) < 10) p = POS_W'($urandom_range(4095, 0));
      else p = POS_W'($urandom_range(ACT_DEPTH - 1, 0));
    end
    push_item(m, p, BYTE_W'($urandom_range(255, 0)));
  endtask

  initial begin
    logic [4:0] cs, rs;
    logic [5:0] rw;
    logic [6:0] ic, oc;
    sb               = new();
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_bus.valid     = 1'b0;
    in_bus.mode      = '0;
    in_bus.position  = '0;
    in_bus.data_byte = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // every store entry written before any compute reads it
    for (int k = 0; k < WGT_DEPTH; k++)
      push_item(MODE_WEIGHT, POS_W'(k), BYTE_W'($urandom_range(255, 0)));
    for (int k = 0; k < ACT_DEPTH; k++)
      push_item(MODE_ACT_FIRST, POS_W'(k), BYTE_W'($urandom_range(255, 0)));
    for (int k = 0; k < ACT_DEPTH; k++)
      push_item(MODE_ACT_SECOND, POS_W'(k), BYTE_W'($urandom_range(255, 0)));

    // reset settings: field extremes, loads past the stores
    push_item(MODE_COMPUTE, 12'd0, 8'h00);
    push_item(MODE_COMPUTE, 12'd2047, 8'hFF);
    push_item(MODE_COMPUTE, 12'd2048, 8'h80);
    push_item(MODE_COMPUTE, 12'd4095, 8'h7F);
    push_item(MODE_WEIGHT, 12'd4095, 8'h80);
    push_item(MODE_WEIGHT, 12'd0, 8'h7F);
    push_item(MODE_ACT_FIRST, 12'd1023, 8'hFF);
    push_item(MODE_ACT_SECOND, 12'd0, 8'h00);
    push_item(MODE_ACT_FIRST, 12'd4095, 8'h55);
    push_item(MODE_ACT_SECOND, 12'd1024, 8'hAA);
    push_item(MODE_COMPUTE, 12'd7, 8'h80);
    push_item(MODE_COMPUTE, 12'd2040, 8'h01);

    // no conv rounding, plain residual add, zero width, too few in channels
    configure(5'd0, 5'd0, 6'd0, 7'd0, 7'd127, 1'b0);
    push_item(MODE_COMPUTE, 12'd0, 8'hFF);
    push_item(MODE_COMPUTE, 12'd63, 8'h80);
    push_item(MODE_COMPUTE, 12'd64, 8'h10);
    // saturated width and in channels, no output block at all
    configure(5'd31, 5'd31, 6'd63, 7'd127, 7'd7, 1'b1);
    push_item(MODE_COMPUTE, 12'd0, 8'h80);
    // smallest legal shape
    configure(5'd1, 5'd1, 6'd1, 7'd16, 7'd8, 1'b0);
    push_item(MODE_COMPUTE, 12'd5, 8'hC8);
    push_item(MODE_COMPUTE, 12'd8, 8'h01);
    // channel counts off the grid, width just past the maximum
    configure(5'd9, 5'd1, 6'd33, 7'd40, 7'd20, 1'b1);
    push_item(MODE_COMPUTE, 12'd0, 8'hFE);
    push_item(MODE_COMPUTE, 12'd511, 8'h33);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      cs = ($urandom_range(99) < 70) ? 5'($urandom_range(14, 6)) : 5'($urandom_range(31, 0));
      case ($urandom_range(9))
        0, 1, 2, 3, 4: rs = 5'd0;
        5, 6, 7:       rs = 5'($urandom_range(3, 1));
        default:       rs = 5'($urandom_range(31, 0));
      endcase
      rw = ($urandom_range(99) < 80) ? 6'($urandom_range(32, 1)) : 6'($urandom_range(63, 0));
      ic = ($urandom_range(99) < 80) ? 7'(16 * $urandom_range(4, 1))
                                     : 7'($urandom_range(127, 0));
      oc = ($urandom_range(99) < 80) ? 7'(8 * $urandom_range(8, 1))
                                     : 7'($urandom_range(127, 0));
      configure(cs, rs, rw, ic, oc, 1'($urandom_range(1, 0)));
      idle_pct = (ph == 5) ? 0 : 38;
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    while (sb.expected_pixels.size() != 0)
      sb.report($sformatf("no result for position %0d",
                          sb.expected_pixels.pop_front().position));
    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
hdl/pcrr_pkg.sv
hdl/pcrr_if.sv
hdl/pcrr_mac.sv
hdl/pointwise_conv_residual_requant.sv
bench/pointwise_conv_residual_requant_tb.sv
